FILE: hdl/itoa_pkg.sv
// Shared types and constants for the decimal text emitter.
package itoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [BCD_W-1:0]   bcd_t;
  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

FILE: hdl/itoa_bcd_step.sv
// One shift-add-3 step of the binary to BCD converter.
module itoa_bcd_step (
  input  itoa_pkg::bcd_t bcd_in,
  input  logic           bit_in,
  output itoa_pkg::bcd_t bcd_out
);

  itoa_pkg::bcd_t adjusted;

  // Add three to every digit of five or more, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < int'(itoa_pkg::NUM_DIGITS); i++) begin
      if (bcd_in[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] >= 4'd5) begin
        adjusted[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
          bcd_in[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] + 4'd3;
      end else begin
        adjusted[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
          bcd_in[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W];
      end
    end
  end

  assign bcd_out = {adjusted[itoa_pkg::BCD_W-2:0], bit_in};

endmodule

FILE: hdl/integer_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text emitter.
//
// Usage:
//   Input channel (value, value_valid, value_ready) takes one two's complement
//   32-bit integer per request. Output channel (text_char, last, text_valid,
//   text_ready) returns its decimal text one ASCII character per request: a
//   leading '-' for negative values, then the digits most significant first
//   with no leading zeros ('0' alone for zero). last marks the final character.
//   Operation:
//   The magnitude is converted to ten BCD digits by one shift-add-3 unit that
//   is reused for every input bit, one input bit per cycle. The sequencer then
//   passes through the sign state and walks the digits from the top (leading
//   zeros are dropped without output). A new value is not taken until the last
//   digit is sent; value_ready is high only while the sequencer is idle.
//   Stalls:
//   Characters go through a one-entry output register; while the receiver
//   holds text_ready low the register holds its character and the sequencer
//   waits before loading the next one. A new value can be accepted while the
//   final character still waits. Reset (rst, synchronous) returns the
//   sequencer to idle and empties the output register.
module integer_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [itoa_pkg::VALUE_W-1:0]  value,
  input  logic                                 value_valid,
  output logic                                 value_ready,
  output logic        [itoa_pkg::CHAR_W-1:0]   text_char,
  output logic                                 last,
  output logic                                 text_valid,
  input  logic                                 text_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_SIGN,
    S_DIGITS
  } state_t;

  state_t                         state;
  logic                           neg;
  logic [itoa_pkg::VALUE_W-1:0]   mag;
  itoa_pkg::bcd_t                 bcd;
  itoa_pkg::bcd_t                 bcd_next;
  logic [4:0]                     bit_cnt;
  logic [3:0]                     digit_idx;
  logic                           started;

  logic                           out_free;
  logic                           skip_zero;
  logic                           emit;
  itoa_pkg::digit_t               top_digit;

  // Shared conversion unit: one input bit per cycle, MSB first.
  itoa_bcd_step u_step (
    .bcd_in  (bcd),
    .bit_in  (mag[itoa_pkg::VALUE_W-1]),
    .bcd_out (bcd_next)
  );

  assign value_ready = (state == S_IDLE);
  assign out_free    = !text_valid || text_ready;
  assign top_digit   = bcd[itoa_pkg::BCD_W-1 -: itoa_pkg::DIGIT_W];
  // Leading zero to drop; the last digit is always shown.
  assign skip_zero   = (top_digit == '0) && !started && (digit_idx != '0);
  // Load a new character into the output register this cycle.
  assign emit        = out_free && (((state == S_SIGN) && neg) ||
                                    ((state == S_DIGITS) && !skip_zero));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      text_valid <= 1'b0;
    end else begin
      // Raise valid on a new character; drop the held one once the receiver takes it.
      if (emit) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (value_valid) begin
            neg     <= value[itoa_pkg::VALUE_W-1];
            // Unsigned negate so the most negative value keeps its magnitude.
            mag     <= value[itoa_pkg::VALUE_W-1] ? (~$unsigned(value) + 32'd1)
                                                  : $unsigned(value);
            bcd     <= '0;
            bit_cnt <= '0;
            state   <= S_CONVERT;
          end
        end

        S_CONVERT: begin
          bcd     <= bcd_next;
          mag     <= {mag[itoa_pkg::VALUE_W-2:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == 5'(itoa_pkg::VALUE_W - 1)) begin
            digit_idx <= 4'(itoa_pkg::NUM_DIGITS - 1);
            started   <= 1'b0;
            state     <= S_SIGN;
          end
        end

        S_SIGN: begin
          if (!neg) begin
            state <= S_DIGITS;
          end else if (out_free) begin
            text_char <= itoa_pkg::ASCII_MINUS;
            last      <= 1'b0;
            state     <= S_DIGITS;
          end
        end

        S_DIGITS: begin
          if (skip_zero) begin
            // Skip a leading zero without output.
            bcd       <= {bcd[itoa_pkg::BCD_W-itoa_pkg::DIGIT_W-1:0], 4'd0};
            digit_idx <= digit_idx - 4'd1;
          end else if (out_free) begin
            text_char <= itoa_pkg::ASCII_ZERO | {4'd0, top_digit};
            last      <= (digit_idx == '0);
            started   <= 1'b1;
            bcd       <= {bcd[itoa_pkg::BCD_W-itoa_pkg::DIGIT_W-1:0], 4'd0};
            if (digit_idx == '0) begin
              state <= S_IDLE;
            end else begin
              digit_idx <= digit_idx - 4'd1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_integer_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII emitter, with a self-checking scoreboard.
`timescale 1ns / 100ps

module tb_integer_to_decimal_ascii;

  // One expected character of a number's text.
  typedef struct {
    logic [itoa_pkg::CHAR_W-1:0] ch;
    logic                        fin;
  } text_char_t;

  // Holds the characters still owed by the block and counts mismatches.
  class decimal_text_checker;
    text_char_t owed_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Predict the decimal text of an accepted request and queue its characters.
    function void note_value(logic [itoa_pkg::VALUE_W-1:0] v);
      logic [itoa_pkg::VALUE_W-1:0] mag;
      itoa_pkg::digit_t             dig[itoa_pkg::NUM_DIGITS];
      int                           nd;
      text_char_t                   item;
      // Take the magnitude as unsigned so the most negative value stays whole.
      mag = v[itoa_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
      nd  = 0;
      do begin
        dig[nd] = itoa_pkg::digit_t'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0);
      if (v[itoa_pkg::VALUE_W-1]) begin
        item.ch  = itoa_pkg::ASCII_MINUS;
        item.fin = 1'b0;
        owed_chars.push_back(item);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        item.ch  = itoa_pkg::ASCII_ZERO + {4'd0, dig[k]};
        item.fin = (k == 0);
        owed_chars.push_back(item);
      end
    endfunction

    // Compare one accepted character with the oldest one owed.
    function void check_char(logic [itoa_pkg::CHAR_W-1:0] ch, logic fin);
      text_char_t want;
      if (owed_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char=%0d last=%0b",
                 $time, ch, fin);
        errors++;
        return;
      end
      want = owed_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: text_char mismatch: expected %0d, actual %0d", $time, want.ch, ch);
        errors++;
      end
      if (fin !== want.fin) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return owed_chars.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic signed [itoa_pkg::VALUE_W-1:0] value = '0;
  logic                                value_valid = 1'b0;
  logic                                value_ready;
  logic        [itoa_pkg::CHAR_W-1:0]  text_char;
  logic                                last;
  logic                                text_valid;
  logic                                text_ready = 1'b0;

  // When set, both sides run back to back with no idle cycles.
  bit                                  quiet = 1'b0;

  decimal_text_checker text_book = new();

  integer_to_decimal_ascii dut (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .text_char   (text_char),
    .last        (last),
    .text_valid  (text_valid),
    .text_ready  (text_ready)
  );

  always #5 clk = ~clk;

  // Draw an idle count for one request, none while running quiet.
  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Draw a value: mostly numbers of a chosen digit count, some raw 32-bit words.
  function automatic logic [itoa_pkg::VALUE_W-1:0] draw_value();
    int unsigned                  sel;
    int unsigned                  ndig;
    longint unsigned              lim;
    longint unsigned              r;
    logic [itoa_pkg::VALUE_W-1:0] m;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom();
    ndig = $urandom_range(1, 10);
    lim  = 1;
    for (int k = 0; k < ndig; k++) lim = lim * 10;
    r = longint'($urandom()) % lim;
    m = r[itoa_pkg::VALUE_W-1:0];
    if ($urandom_range(0, 1) == 1) m = ~m + 1'b1;
    return m;
  endfunction

  // Offer one request after an idle gap and hold it until the block takes it.
  // Entered at a rising edge; returns at the edge that accepted the request.
  task automatic send_value(input logic [itoa_pkg::VALUE_W-1:0] v, input int gap);
    if (gap > 0) begin
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value       <= v;
    value_valid <= 1'b1;
    do @(posedge clk); while (!value_ready);
    text_book.note_value(v);
  endtask

  // Drop valid and hold off until every owed character has come back.
  task automatic drain_text();
    value_valid <= 1'b0;
    @(posedge clk);
    while (text_book.pending() != 0) @(posedge clk);
  endtask

  // Receiver: stall a random number of cycles, then take one character.
  initial begin : text_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        text_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      text_ready <= 1'b1;
      do @(posedge clk); while (!text_valid);
      text_book.check_char(text_char, last);
    end
  end

  // Sender: directed edge values, then random values in mixed idle phases.
  initial begin : value_source
    logic [itoa_pkg::VALUE_W-1:0] directed[$];
    directed = {32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                32'd999999999, -32'sd999999999, 32'h5555_5555, 32'hAAAA_AAAA,
                32'd1234567890, -32'sd1234567890, 32'd7, -32'sd7, 32'd65535,
                -32'sd32768};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i], draw_gap());

    // Let the directed text drain completely before the random part.
    drain_text();

    for (int i = 0; i < 480; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == 240) drain_text();
      send_value(draw_value(), draw_gap());
    end
    value_valid <= 1'b0;

    while (text_book.pending() != 0) @(posedge clk);
    // Give a stray extra character time to show up.
    repeat (60) @(posedge clk);

    if (text_book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hdl/itoa_pkg.sv
hdl/itoa_bcd_step.sv
hdl/integer_to_decimal_ascii.sv
tb/tb_integer_to_decimal_ascii.sv
